>>> rtl/kmpff_pkg.sv
package kmpff_pkg;

  // Operation codes carried in the input item
  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned RESULT_BITS = 32;

  // One input item
  typedef struct packed {
    logic                 op;
    logic [BYTE_BITS-1:0] data_byte;
    logic                 last;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic                   found;
    logic [RESULT_BITS-1:0] position;
  } out_item_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAT_INIT,
    ST_CMP,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // take the item on the input port
    logic load_fail;  // start the pattern walk from the previous failure entry
    logic step;       // one compare / failure-chain step
    logic finish;     // commit the outcome of this item
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pat_fits;      // pattern byte has room in the store
    logic pat_first;     // pattern byte is the first of its pattern
    logic text_walk;     // text byte needs a search step
    logic eq;            // stored byte at k equals the current byte
    logic k_zero;        // match length is zero
    logic emit_blocked;  // a result is due but the output register is held
  } status_t;

endpackage

>>> rtl/kmpff_controller.sv
module kmpff_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_op,
  output logic              item_stall,
  input  kmpff_pkg::status_t st,
  output kmpff_pkg::cmd_t    cmd
);
  import kmpff_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (item_op == OP_PATTERN) begin
            if (!st.pat_fits) begin
              state_next = ST_IDLE;
            end else if (st.pat_first) begin
              state_next = ST_FINISH;
            end else begin
              state_next = ST_PAT_INIT;
            end
          end else begin
            state_next = st.text_walk ? ST_CMP : ST_FINISH;
          end
        end
      end
      ST_PAT_INIT: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (st.eq || st.k_zero) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!st.emit_blocked) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs; no transfer is taken while reset is held
  always_comb begin
    item_stall    = 1'b1;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        item_stall = rst;
        cmd.accept = item_valid && !rst;
      end
      ST_PAT_INIT: begin
        cmd.load_fail = 1'b1;
      end
      ST_CMP: begin
        cmd.step = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = !st.emit_blocked;
      end
      default: begin
        item_stall = 1'b1;
      end
    endcase
  end

endmodule

>>> rtl/kmpff_datapath.sv
module kmpff_datapath #(
  parameter int unsigned PATTERN_MAX   = 32,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  kmpff_pkg::in_item_t  item,
  input  kmpff_pkg::cmd_t      cmd,
  output kmpff_pkg::status_t   st,
  output logic                 result_valid,
  input  logic                 result_stall,
  output kmpff_pkg::out_item_t result
);
  import kmpff_pkg::*;

  localparam int unsigned KW = $clog2(PATTERN_MAX + 1);
  localparam int unsigned AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned PW = (POSITION_BITS > RESULT_BITS) ? POSITION_BITS : RESULT_BITS;

  // Pattern bytes and failure entries
  logic [BYTE_BITS-1:0] pattern_store [PATTERN_MAX];
  logic [KW-1:0]        failure_table [PATTERN_MAX];
  logic [BYTE_BITS-1:0] pat_rd;
  logic [KW-1:0]        fail_rd;

  // Pattern and search state
  logic [KW-1:0]            pattern_length;
  logic                     pattern_closed;
  logic [KW-1:0]            matched_count;
  logic [POSITION_BITS-1:0] text_index;
  logic                     match_done;

  // Current item and walk register
  logic                 op;
  logic [BYTE_BITS-1:0] data_byte;
  logic                 last;
  logic                 walked;
  logic [KW-1:0]        k;
  logic [KW-1:0]        k_next;
  logic [KW-1:0]        k_dec;

  logic [KW-1:0]        eff_len;
  logic                 match_now;
  logic                 done_after;
  logic                 need_emit;
  logic [PW-1:0]        pos_full;

  assign eff_len   = pattern_closed ? '0 : pattern_length;
  assign match_now = (op == OP_TEXT) && walked && (k == pattern_length);
  assign done_after = match_done | match_now;
  assign need_emit = (op == OP_TEXT) && (match_now || (last && !done_after));
  assign pos_full  = PW'(text_index) - PW'(pattern_length - KW'(1));

  // Status toward the controller
  always_comb begin
    st.pat_fits     = eff_len < KW'(PATTERN_MAX);
    st.pat_first    = eff_len == '0;
    st.text_walk    = !match_done && (pattern_length != '0);
    st.eq           = pat_rd == data_byte;
    st.k_zero       = k == '0;
    st.emit_blocked = need_emit && result_valid && result_stall;
  end

  // Next match length
  always_comb begin
    k_next = k;
    if (cmd.accept) begin
      k_next = (item.op == OP_PATTERN) ? eff_len : matched_count;
    end else if (cmd.load_fail) begin
      k_next = fail_rd;
    end else if (cmd.step) begin
      if (pat_rd == data_byte) begin
        k_next = k + KW'(1);
      end else if (k != '0) begin
        k_next = fail_rd;
      end
    end
  end

  assign k_dec = k_next - KW'(1);

  // Memories: read at the next k, so data lines up with k
  always_ff @(posedge clk) begin
    if (cmd.accept && (item.op == OP_PATTERN) && st.pat_fits) begin
      pattern_store[eff_len[AW-1:0]] <= item.data_byte;
    end
    pat_rd <= pattern_store[k_next[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && (op == OP_PATTERN)) begin
      failure_table[pattern_length[AW-1:0]] <= k;
    end
    fail_rd <= failure_table[k_dec[AW-1:0]];
  end

  // Item and walk registers
  always_ff @(posedge clk) begin
    k <= k_next;
    if (cmd.accept) begin
      op        <= item.op;
      data_byte <= item.data_byte;
      last      <= item.last;
      walked    <= st.text_walk;
    end
  end

  // Pattern and search state
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      pattern_closed <= 1'b0;
      matched_count  <= '0;
      text_index     <= '0;
      match_done     <= 1'b0;
    end else if (cmd.accept && (item.op == OP_PATTERN)) begin
      pattern_closed <= item.last;
      if (pattern_closed) begin
        pattern_length <= '0;
      end
      matched_count <= '0;
      text_index    <= '0;
      match_done    <= 1'b0;
    end else if (cmd.finish) begin
      if (op == OP_PATTERN) begin
        pattern_length <= pattern_length + KW'(1);
      end else if (last) begin
        matched_count <= '0;
        text_index    <= '0;
        match_done    <= 1'b0;
      end else begin
        if (walked) begin
          matched_count <= match_now ? '0 : k;
        end
        match_done <= done_after;
        if (text_index != '1) begin
          text_index <= text_index + POSITION_BITS'(1);
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish && need_emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && need_emit) begin
      result.found    <= match_now;
      result.position <= match_now ? pos_full[RESULT_BITS-1:0] : '0;
    end
  end

endmodule

>>> rtl/kmp_first_match_finder_core.sv
// Sequence: a searched text byte is taken in ST_IDLE, follows s failure links in
// ST_CMP (one compare per cycle), commits in ST_FINISH and only then lets a new
// byte in. A pattern byte passes ST_PAT_INIT, ST_CMP and ST_FINISH, but only
// ST_FINISH at its first position and none once the store is full; a text byte after a
// match or with no pattern passes only ST_FINISH. s averages at most one per byte.
// Reset (rst, synchronous): clears pattern length, search state and output valid.
module kmp_first_match_finder_core #(
  parameter int unsigned PATTERN_MAX   = 32,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  kmpff_pkg::in_item_t  item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output kmpff_pkg::out_item_t result
);
  import kmpff_pkg::*;

  cmd_t    cmd;
  status_t st;

  // Sequencer
  kmpff_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_op    (item.op),
    .item_stall (item_stall),
    .st         (st),
    .cmd        (cmd)
  );

  // Memories, search state and output register
  kmpff_datapath #(
    .PATTERN_MAX   (PATTERN_MAX),
    .POSITION_BITS (POSITION_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .st           (st),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

>>> rtl/kmpff_checker.sv
module kmpff_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_valid,
  input logic                 item_stall,
  input kmpff_pkg::in_item_t  item,
  input logic                 result_valid,
  input logic                 result_stall,
  input kmpff_pkg::out_item_t result
);
  import kmpff_pkg::*;

  // A held result keeps its value until the transfer
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // Not-found results carry position zero
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |-> result.position == '0)
    else $error("not-found result with nonzero position");

  // Pattern bytes never produce a result
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (item.op == OP_PATTERN) && !result_valid
    |=> !result_valid)
    else $error("result after a pattern byte");

  // No result right after reset
  assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid after reset");

endmodule

bind kmp_first_match_finder_core kmpff_checker u_kmpff_checker (.*);
